/* rtl/bts_pkg.sv */
package bts_pkg;

   // fixed field widths of the command and response beats
   localparam int TASK_W = 5;
   localparam int LIST_W = 3;
   localparam int TIME_W = 32;
   localparam int LINK_W = 4;

   // service commands
   typedef enum logic [2:0] {
      CMD_SELECT     = 3'd0,
      CMD_READY      = 3'd1,
      CMD_BLOCK_LIST = 3'd2,
      CMD_BLOCK_DL   = 3'd3,
      CMD_BLOCK_BOTH = 3'd4,
      CMD_SIGNAL     = 3'd5,
      CMD_TICK       = 3'd6,
      CMD_TERM       = 3'd7
   } cmd_type;

   // one write into the per-task store
   typedef struct packed {
      logic              dl_we;
      logic              link_we;
      logic [TASK_W-1:0] addr;
      logic [TIME_W-1:0] deadline;
      logic [LINK_W-1:0] link;
   } store_wr_type;

   // index of the lowest set bit, 0 when none is set
   function automatic logic [TASK_W-1:0] lowest_set(input logic [31:0] m);
      logic [TASK_W-1:0] idx;
      idx = '0;
      for (int i = 31; i >= 0; i--) begin
         if (m[i]) begin
            idx = TASK_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/bitmap_task_scheduler_top.sv */
// channel    | ports                                | handshake
// -----------+--------------------------------------+---------------------------
// command    | req_command .. req_current_time      | start high, busy low
// response   | rsp_running_valid .. rsp_last_result | rsp_valid, one cycle each
//
// select, make ready, block, signal and terminate: response on the next cycle,
// a new command may start in that same cycle
// tick: busy for the walk through the deadline memory at one entry per cycle;
// woken tasks come out in ascending order
// reset clears all bitmaps and link valid bits at once, no clearing pass
// the receiver cannot stall: every response beat is taken in its cycle
module bitmap_task_scheduler_top #(
   parameter int TASK_SLOTS = 32,
   parameter int WAIT_LISTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_command,
   input  logic [bts_pkg::TASK_W-1:0]  req_task_number,
   input  logic [bts_pkg::LIST_W-1:0]  req_list_number,
   input  logic [bts_pkg::TIME_W-1:0]  req_deadline_time,
   input  logic [bts_pkg::TIME_W-1:0]  req_current_time,
   output logic                        rsp_valid,
   output logic                        rsp_running_valid,
   output logic [bts_pkg::TASK_W-1:0]  rsp_running_task,
   output logic                        rsp_woken_valid,
   output logic [bts_pkg::TASK_W-1:0]  rsp_woken_task,
   output logic                        rsp_wake_code,
   output logic                        rsp_ignored,
   output logic                        rsp_last_result
);
   import bts_pkg::*;

   localparam int TIDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int LIDX_W = (WAIT_LISTS > 1) ? $clog2(WAIT_LISTS) : 1;
   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);

   typedef enum logic {ST_IDLE, ST_TICK} state_type;

   state_type             state_ff;
   logic [TASK_SLOTS-1:0] ready_ff;
   logic [TASK_SLOTS-1:0] dlm_ff;
   logic [TASK_SLOTS-1:0] wait_ff [WAIT_LISTS];
   logic                  run_vld_ff;
   logic [TASK_W-1:0]     run_idx_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  stg_vld_ff;
   logic [TASK_W-1:0]     stg_t_ff;
   logic                  pend_vld_ff;
   logic [TASK_W-1:0]     pend_t_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_rv_ff;
   logic [TASK_W-1:0]     rsp_rt_ff;
   logic                  rsp_wv_ff;
   logic [TASK_W-1:0]     rsp_wt_ff;
   logic                  rsp_wc_ff;
   logic                  rsp_ign_ff;
   logic                  rsp_last_ff;

   cmd_type               cmd;
   logic                  accept;
   logic                  task_ok;
   logic                  list_ok;
   logic                  blk_ok;
   logic                  blk_cmd;
   logic                  sig_wake;
   logic [LIDX_W-1:0]     list_idx;
   logic [TASK_SLOTS-1:0] run_bit;
   logic [TASK_SLOTS-1:0] sel_mask;
   logic [TASK_W-1:0]     sel_lo;
   logic [TASK_SLOTS-1:0] sig_mask;
   logic [TASK_W-1:0]     sig_lo;
   logic                  run_vld_in;
   logic [TASK_W-1:0]     run_idx_in;
   logic                  rd_en;
   logic [TIME_W-1:0]     rd_deadline;
   logic [LINK_W-1:0]     rd_link;
   logic [LINK_W-1:0]     link_m1;
   logic                  link_ok;
   logic                  tick_hit;
   logic                  scan_done;
   store_wr_type          st_wr;

   // command decode
   assign cmd      = cmd_type'(req_command);
   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign task_ok  = 32'(req_task_number) < TASK_SLOTS;
   assign list_ok  = 32'(req_list_number) < WAIT_LISTS;
   assign list_idx = LIDX_W'(req_list_number);
   assign blk_ok   = (cmd == CMD_BLOCK_DL) || list_ok;
   assign blk_cmd  = (cmd == CMD_BLOCK_LIST) || (cmd == CMD_BLOCK_DL)
                     || (cmd == CMD_BLOCK_BOTH);
   assign run_bit  = TASK_SLOTS'(1) << run_idx_ff[TIDX_W-1:0];

   // lowest ready task, with the running task put back first
   assign sel_mask = ready_ff | (run_vld_ff ? run_bit : '0);
   assign sel_lo   = lowest_set(32'(sel_mask));

   // lowest waiter of the signalled list
   assign sig_mask = list_ok ? wait_ff[list_idx] : '0;
   assign sig_lo   = lowest_set(32'(sig_mask));
   assign sig_wake = (cmd == CMD_SIGNAL) && (|sig_mask);

   // running task after a command that is not a tick
   always_comb begin
      run_vld_in = run_vld_ff;
      run_idx_in = run_idx_ff;
      unique case (cmd)
         CMD_SELECT: begin
            run_vld_in = |sel_mask;
            if (|sel_mask) begin
               run_idx_in = sel_lo;
            end
         end
         CMD_BLOCK_LIST, CMD_BLOCK_DL, CMD_BLOCK_BOTH: begin
            if (run_vld_ff && blk_ok) begin
               run_vld_in = 1'b0;
            end
         end
         CMD_TERM: begin
            run_vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // deadline scan: read issued one cycle, compared the next
   assign rd_en     = (state_ff == ST_TICK) && (cnt_ff < CNT_W'(TASK_SLOTS));
   assign scan_done = (state_ff == ST_TICK) && (cnt_ff == CNT_W'(TASK_SLOTS)) && !stg_vld_ff;
   assign tick_hit  = (state_ff == ST_TICK) && stg_vld_ff
                      && dlm_ff[stg_t_ff[TIDX_W-1:0]] && (now_ff >= rd_deadline);
   assign link_m1   = rd_link - LINK_W'(1);
   assign link_ok   = (rd_link != '0) && (32'(link_m1) < WAIT_LISTS);

   // store writes; scan writes never touch the entry read in the same cycle
   always_comb begin
      st_wr      = '0;
      st_wr.addr = run_idx_ff;
      if (tick_hit) begin
         st_wr.link_we = 1'b1;
         st_wr.addr    = stg_t_ff;
      end else if (accept) begin
         unique case (cmd)
            CMD_READY: begin
               st_wr.link_we = task_ok;
               st_wr.addr    = req_task_number;
            end
            CMD_BLOCK_LIST, CMD_BLOCK_DL, CMD_BLOCK_BOTH: begin
               if (run_vld_ff && blk_ok) begin
                  st_wr.link_we  = (cmd != CMD_BLOCK_DL);
                  st_wr.link     = LINK_W'(req_list_number) + LINK_W'(1);
                  st_wr.dl_we    = (cmd != CMD_BLOCK_LIST);
                  st_wr.deadline = req_deadline_time;
               end
            end
            CMD_SIGNAL: begin
               st_wr.link_we = |sig_mask;
               st_wr.addr    = sig_lo;
            end
            default: begin
            end
         endcase
      end
   end

   bts_task_store #(
      .TASK_SLOTS (TASK_SLOTS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (st_wr),
      .rd_en       (rd_en),
      .rd_addr     (TASK_W'(cnt_ff)),
      .rd_deadline (rd_deadline),
      .rd_link     (rd_link)
   );

   // sequencer, bitmaps and response beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ready_ff     <= '0;
         dlm_ff       <= '0;
         for (int l = 0; l < WAIT_LISTS; l++) begin
            wait_ff[l] <= '0;
         end
         run_vld_ff   <= 1'b0;
         run_idx_ff   <= '0;
         cnt_ff       <= '0;
         stg_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               // a tick answers only after its scan
               rsp_valid_ff <= accept && (cmd != CMD_TICK);
               if (accept) begin
                  run_vld_ff   <= run_vld_in;
                  run_idx_ff   <= run_idx_in;
                  rsp_rv_ff    <= run_vld_in;
                  rsp_rt_ff    <= run_vld_in ? run_idx_in : '0;
                  rsp_wv_ff    <= sig_wake;
                  rsp_wt_ff    <= sig_wake ? sig_lo : '0;
                  rsp_wc_ff    <= sig_wake;
                  rsp_ign_ff   <= blk_cmd && !run_vld_ff;
                  rsp_last_ff  <= 1'b1;
                  unique case (cmd)
                     CMD_SELECT: begin
                        ready_ff <= sel_mask & ~(TASK_SLOTS'(1) << sel_lo[TIDX_W-1:0]);
                     end
                     CMD_READY: begin
                        if (task_ok) begin
                           ready_ff[req_task_number[TIDX_W-1:0]] <= 1'b1;
                        end
                     end
                     CMD_BLOCK_LIST, CMD_BLOCK_DL, CMD_BLOCK_BOTH: begin
                        if (run_vld_ff && blk_ok) begin
                           if (cmd != CMD_BLOCK_DL) begin
                              wait_ff[list_idx][run_idx_ff[TIDX_W-1:0]] <= 1'b1;
                           end
                           if (cmd != CMD_BLOCK_LIST) begin
                              dlm_ff[run_idx_ff[TIDX_W-1:0]] <= 1'b1;
                           end
                        end
                     end
                     CMD_SIGNAL: begin
                        if (sig_wake) begin
                           dlm_ff[sig_lo[TIDX_W-1:0]]            <= 1'b0;
                           wait_ff[list_idx][sig_lo[TIDX_W-1:0]] <= 1'b0;
                           ready_ff[sig_lo[TIDX_W-1:0]]          <= 1'b1;
                        end
                     end
                     CMD_TICK: begin
                        state_ff     <= ST_TICK;
                        now_ff       <= req_current_time;
                        cnt_ff       <= '0;
                        stg_vld_ff   <= 1'b0;
                        pend_vld_ff  <= 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_TICK: begin
               rsp_valid_ff <= (tick_hit && pend_vld_ff) || scan_done;
               // issue the next read
               stg_vld_ff <= rd_en;
               stg_t_ff   <= TASK_W'(cnt_ff);
               if (rd_en) begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
               // wake on expired deadline; the previous wake goes out now
               if (tick_hit) begin
                  dlm_ff[stg_t_ff[TIDX_W-1:0]]   <= 1'b0;
                  ready_ff[stg_t_ff[TIDX_W-1:0]] <= 1'b1;
                  if (link_ok) begin
                     wait_ff[LIDX_W'(link_m1)][stg_t_ff[TIDX_W-1:0]] <= 1'b0;
                  end
                  pend_vld_ff <= 1'b1;
                  pend_t_ff   <= stg_t_ff;
                  if (pend_vld_ff) begin
                     rsp_rv_ff    <= run_vld_ff;
                     rsp_rt_ff    <= run_vld_ff ? run_idx_ff : '0;
                     rsp_wv_ff    <= 1'b1;
                     rsp_wt_ff    <= pend_t_ff;
                     rsp_wc_ff    <= 1'b0;
                     rsp_ign_ff   <= 1'b0;
                     rsp_last_ff  <= 1'b0;
                  end
               end
               // final beat: the held wake, or a beat with nobody woken
               if (scan_done) begin
                  state_ff     <= ST_IDLE;
                  rsp_rv_ff    <= run_vld_ff;
                  rsp_rt_ff    <= run_vld_ff ? run_idx_ff : '0;
                  rsp_wv_ff    <= pend_vld_ff;
                  rsp_wt_ff    <= pend_vld_ff ? pend_t_ff : '0;
                  rsp_wc_ff    <= 1'b0;
                  rsp_ign_ff   <= 1'b0;
                  rsp_last_ff  <= 1'b1;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_running_valid = rsp_rv_ff;
   assign rsp_running_task  = rsp_rt_ff;
   assign rsp_woken_valid   = rsp_wv_ff;
   assign rsp_woken_task    = rsp_wt_ff;
   assign rsp_wake_code     = rsp_wc_ff;
   assign rsp_ignored       = rsp_ign_ff;
   assign rsp_last_result   = rsp_last_ff;

   // a beat that is not the last one only comes out of a running scan
   a_mid_beat_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_result) |-> busy)
      else $error("non-final beat outside a tick scan");

   // a signalled wake is always a single, final beat
   a_signal_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake_code) |-> (rsp_last_result && rsp_woken_valid))
      else $error("signal wake not reported as a single beat");

   // a tick never changes the running task
   a_tick_run_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |=> ($stable(run_vld_ff) && $stable(run_idx_ff)))
      else $error("running task changed during a tick scan");

   // the scan counter stays within the task slots
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) |-> (cnt_ff <= CNT_W'(TASK_SLOTS)))
      else $error("scan counter past the last task slot");

endmodule

/* rtl/bts_task_store.sv */
module bts_task_store #(
   parameter int TASK_SLOTS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bts_pkg::store_wr_type         wr,
   input  logic                          rd_en,
   input  logic [bts_pkg::TASK_W-1:0]    rd_addr,
   output logic [bts_pkg::TIME_W-1:0]    rd_deadline,
   output logic [bts_pkg::LINK_W-1:0]    rd_link
);
   import bts_pkg::*;

   localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

   logic [TIME_W-1:0]     dl_mem   [TASK_SLOTS];
   logic [LINK_W-1:0]     link_mem [TASK_SLOTS];
   logic [TASK_SLOTS-1:0] link_vld_ff;
   logic [TIME_W-1:0]     dl_rd_ff;
   logic [LINK_W-1:0]     link_rd_ff;
   logic                  link_vld_rd_ff;

   // deadline memory, never cleared: a deadline bit is only set with a write
   always_ff @(posedge clock) begin
      if (wr.dl_we) begin
         dl_mem[wr.addr[AW-1:0]] <= wr.deadline;
      end
      if (rd_en) begin
         dl_rd_ff <= dl_mem[rd_addr[AW-1:0]];
      end
   end

   // wait-list link memory
   always_ff @(posedge clock) begin
      if (wr.link_we) begin
         link_mem[wr.addr[AW-1:0]] <= wr.link;
      end
      if (rd_en) begin
         link_rd_ff <= link_mem[rd_addr[AW-1:0]];
      end
   end

   // per-entry valid bits so a link reads as no list after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff    <= '0;
         link_vld_rd_ff <= 1'b0;
      end else begin
         if (wr.link_we) begin
            link_vld_ff[wr.addr[AW-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            link_vld_rd_ff <= link_vld_ff[rd_addr[AW-1:0]];
         end
      end
   end

   assign rd_deadline = dl_rd_ff;
   assign rd_link     = link_vld_rd_ff ? link_rd_ff : '0;

endmodule
